// ----- design/rcd_pkg.sv -----
// Shared constants, register codes and transaction types of the command deframer.
package rcd_pkg;

    localparam int MAX_PAYLOAD_DEF   = 8;
    localparam int MAX_PAYLOAD_LIMIT = 32;
    localparam int OP_IDX_W          = $clog2(MAX_PAYLOAD_LIMIT + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 1'b1;

    localparam logic [7:0] SYNC_BYTE_RST = 8'h00;
    localparam logic [3:0] FRAME_LEN_RST = 4'd4;

    localparam logic [7:0] NO_COMMAND = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic                store_en;
        logic                vote_en;
        logic [7:0]          data;
        logic [OP_IDX_W-1:0] index;
        logic [OP_IDX_W-1:0] count;
    } rcd_op_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic valid;
    } rcd_q_status_t;

endpackage

// ----- design/rcd_front.sv -----
// Front end: configuration registers, header hunt and payload classification.
module rcd_front #(
    parameter int MAX_PAYLOAD = rcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    output logic                           op_valid,
    output rcd_pkg::rcd_op_t               op
);
    import rcd_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]       header_reg;
    logic [3:0]       frame_len_reg;
    logic             in_payload_reg, in_payload_next;
    logic             header_run_reg, header_run_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [IDX_W-1:0] n_eff;
    logic [IDX_W-1:0] idx_inc;
    logic             is_hdr;
    logic             do_store;
    logic             done;

    always_comb
    begin
        n_eff    = (32'(frame_len_reg) > MAX_PAYLOAD) ? IDX_W'(MAX_PAYLOAD)
                                                      : IDX_W'(frame_len_reg);
        is_hdr   = (rx_byte == header_reg);
        do_store = !is_hdr && (32'(idx_reg) < MAX_PAYLOAD);
        idx_inc  = idx_reg + IDX_W'(do_store);
        done     = (idx_inc >= n_eff);

        in_payload_next = in_payload_reg;
        header_run_next = header_run_reg;
        idx_next        = idx_reg;
        op_valid        = 1'b0;

        if (accept)
        begin
            if (!in_payload_reg)
            begin
                if (is_hdr)
                begin
                    if (header_run_reg)
                    begin
                        in_payload_next = 1'b1;
                        header_run_next = 1'b0;
                        idx_next        = '0;
                    end
                    else
                    begin
                        header_run_next = 1'b1;
                    end
                end
                else
                begin
                    header_run_next = 1'b0;
                end
            end
            else
            begin
                idx_next = idx_inc;
                op_valid = do_store || done;
                if (done)
                begin
                    in_payload_next = 1'b0;
                    idx_next        = '0;
                end
            end
        end

        op.store_en = do_store;
        op.vote_en  = done;
        op.data     = rx_byte;
        op.index    = OP_IDX_W'(idx_reg);
        op.count    = OP_IDX_W'(n_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= SYNC_BYTE_RST;
            frame_len_reg  <= FRAME_LEN_RST;
            in_payload_reg <= 1'b0;
            header_run_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYNC_BYTE: header_reg    <= cfg_data[7:0];
                    REG_FRAME_LEN: frame_len_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            in_payload_reg <= in_payload_next;
            header_run_reg <= header_run_next;
            idx_reg        <= idx_next;
        end
    end

endmodule

// ----- design/rcd_queue.sv -----
// Two-entry queue of classified transactions between front and back.
module rcd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rcd_pkg::rcd_op_t        op_in,
    input  logic                    pop,
    output rcd_pkg::rcd_op_t        op_out,
    output rcd_pkg::rcd_q_status_t  status
);
    import rcd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rcd_op_t          entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign status.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign status.valid = (cnt_reg != '0);
    assign op_out       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.valid)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !status.full) |=> status.valid)
        else $error("queue lost a transaction");

endmodule

// ----- design/rcd_back.sv -----
// Back end: payload store, pairwise vote sweep and output register.
module rcd_back #(
    parameter int MAX_PAYLOAD = rcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  rcd_pkg::rcd_op_t op,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       command,
    output logic             command_found
);
    import rcd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PAYLOAD);
    localparam int IDX_W  = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [7:0]       store_mem [MAX_PAYLOAD];
    logic [7:0]       rd_a_reg, rd_b_reg;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [7:0]       result_reg, result_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       command_reg;
    logic             found_reg;
    logic             out_free;
    logic             load_out;

    assign pop           = (state_reg == ST_IDLE) && op_valid;
    assign out_free      = !out_valid_reg || !out_stall;
    assign load_out      = (state_reg == ST_DONE) && out_free;
    assign out_valid     = out_valid_reg;
    assign command       = command_reg;
    assign command_found = found_reg;

    always_ff @(posedge clk)
    begin
        if (pop && op.store_en)
        begin
            store_mem[op.index[ADDR_W-1:0]] <= op.data;
        end
        if (state_reg == ST_READ)
        begin
            rd_a_reg <= store_mem[i_reg[ADDR_W-1:0]];
            rd_b_reg <= store_mem[j_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop && op.vote_en)
                begin
                    n_next = IDX_W'(op.count);
                    i_next = '0;
                    j_next = IDX_W'(1);
                    if (op.count < OP_IDX_W'(2))
                    begin
                        result_next = NO_COMMAND;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_a_reg == rd_b_reg)
                begin
                    result_next = rd_a_reg;
                    state_next  = ST_DONE;
                end
                else if ((j_reg + IDX_W'(1)) < n_reg)
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
                else if ((i_reg + IDX_W'(2)) < n_reg)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = i_reg + IDX_W'(2);
                    state_next = ST_READ;
                end
                else
                begin
                    result_next = NO_COMMAND;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        result_reg <= result_next;
        if (load_out)
        begin
            command_reg <= result_reg;
            found_reg   <= (result_reg != NO_COMMAND);
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ((j_reg > i_reg) && (j_reg < n_reg)))
        else $error("vote pair out of range");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ($past(state_reg) == ST_READ))
        else $error("compare without a read");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> ($past(state_reg) == ST_IDLE ||
                                    $past(state_reg) == ST_CMP ||
                                    $past(state_reg) == ST_DONE))
        else $error("result without a vote");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output raised outside result state");

endmodule

// ----- design/redundant_command_deframer.sv -----
// Top level of the redundant command deframer: front, queue and back.
//
// Usage: feed received bytes on the input channel (in_valid, rx_byte, in_stall).
// The front hunts for two header bytes in a row, then classifies each payload
// byte and queues a store or end-of-frame transaction. Header-valued payload
// bytes are dropped. The back writes the payload store and, at frame end,
// sweeps the byte pairs (i < j) in order until one matches, reading each pair
// in ST_READ and comparing it in ST_CMP, and reports the first repeated byte
// on the output channel (out_valid, command, command_found, out_stall). command
// is 0xFF and command_found 0 when no byte repeats or when the repeated byte
// is 0xFF. Throughput: one byte per cycle while the two-entry queue has room.
// At frame end the back takes no queued transaction until the vote sweep is
// through and its result is in the output register, which sets the sustained
// rate. When out_stall holds the result, the back waits and the queue fills,
// then in_stall rises.
// Reset: hunting for the header, sync byte 0, frame length 4, no result
// pending. The payload store is not cleared; a frame only reads what it wrote.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 sync byte, 1 frame length) at the clock edge; write only while idle.
module redundant_command_deframer #(
    parameter int MAX_PAYLOAD = rcd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     command,
    output logic                           command_found
);
    import rcd_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    rcd_op_t       front_op;
    rcd_op_t       back_op;
    rcd_q_status_t q_status;

    // Stall whenever the queue is full: any payload byte may need a slot.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    rcd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .op_valid  (push),
        .op        (front_op)
    );

    rcd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .op_in  (front_op),
        .pop    (pop),
        .op_out (back_op),
        .status (q_status)
    );

    rcd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (q_status.valid),
        .op            (back_op),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .command_found (command_found)
    );

endmodule

// ----- tb/sv/tb_redundant_command_deframer.sv -----
// Self-checking testbench of the redundant command deframer: directed table, then random frames.
`timescale 1ns / 100ps

module tb_redundant_command_deframer;

    import rcd_pkg::*;

    // Settle time after the last expected result. It covers a full vote sweep over
    // eight bytes plus the queue, so a byte that makes no result is surely done.
    localparam int SETTLE_CYCLES = 100;
    // Long receiver hold-off, long enough to fill the two-entry queue.
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 95;
    localparam int SCRIPT_LEN    = 31;

    // One voted result: the command byte and its found flag.
    typedef struct packed {
        logic [7:0] command;
        logic       found;
    } verdict_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_kind_t;

    // One row of the directed table. Rows with typed set carry their expected
    // outcome; the rest are checked against the predictor.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [7:0]            value;
        logic                  typed;
        logic                  emit;
        logic [7:0]            command;
        logic                  found;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            command;
    logic                  command_found;

    redundant_command_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .command_found (command_found)
    );

    // Predictor copy of the configuration and of the deframing state.
    logic [7:0] cur_header  = SYNC_BYTE_RST;
    logic [3:0] cur_count   = FRAME_LEN_RST;
    logic       in_frame    = 1'b0;
    logic       header_seen = 1'b0;
    int         stored      = 0;
    logic [7:0] frame_bytes [MAX_PAYLOAD_DEF];

    // Commands expected on the output, oldest first.
    verdict_t pending_commands [$];

    // Expectation typed into the directed row that is currently on the input.
    logic       row_typed;
    logic       row_emit;
    verdict_t   row_verdict;

    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 0;

    row_t script [SCRIPT_LEN];

    logic [3:0] phase_count [PHASES] = '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2,
                                         4'd9, 4'd3, 4'd7, 4'd5, 4'd1, 4'd6};

    // Advance the deframer by one accepted byte. Return 1 when the byte closes a
    // frame, with the voted command in v.
    function automatic bit deframe_byte(input logic [7:0] b, output verdict_t v);
        int         n;
        logic [7:0] pick;
        bit         hit;
        v.command = NO_COMMAND;
        v.found   = 1'b0;
        // Hunt: two header bytes in a row open a frame, anything else restarts.
        if (!in_frame) begin
            if (b == cur_header) begin
                if (header_seen) begin
                    in_frame    = 1'b1;
                    header_seen = 1'b0;
                    stored      = 0;
                end
                else begin
                    header_seen = 1'b1;
                end
            end
            else begin
                header_seen = 1'b0;
            end
            return 1'b0;
        end
        // Clamp the count to the store size; drop header-valued payload bytes.
        n = (cur_count > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(cur_count);
        if (b != cur_header && stored < MAX_PAYLOAD_DEF) begin
            frame_bytes[stored] = b;
            stored++;
        end
        if (stored < n)
            return 1'b0;
        // Vote: the lowest position whose byte recurs later wins.
        pick = NO_COMMAND;
        hit  = 1'b0;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (!hit && frame_bytes[i] == frame_bytes[j]) begin
                    pick = frame_bytes[i];
                    hit  = 1'b1;
                end
            end
        end
        v.command = pick;
        v.found   = (pick != NO_COMMAND);
        in_frame  = 1'b0;
        stored    = 0;
        return 1'b1;
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("tb_redundant_command_deframer failed");
        $finish;
    end

    // Check every accepted result, then track configuration writes and predict
    // every accepted byte. Everything is sampled at the rising edge.
    always @(posedge clk) begin : scoreboard
        verdict_t want;
        verdict_t v;
        bit       emit;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_commands.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got command %02h found %0b",
                             $time, command, command_found);
                    errors++;
                end
                else begin
                    want = pending_commands.pop_front();
                    if (command !== want.command) begin
                        $display("%0t: command mismatch: expected %02h, got %02h",
                                 $time, want.command, command);
                        errors++;
                    end
                    if (command_found !== want.found) begin
                        $display("%0t: command_found mismatch: expected %0b, got %0b",
                                 $time, want.found, command_found);
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_SYNC_BYTE)
                    cur_header = cfg_data;
                else if (cfg_index == REG_FRAME_LEN)
                    cur_count = cfg_data[3:0];
            end
            if (in_valid && !in_stall) begin
                emit = deframe_byte(rx_byte, v);
                // A typed row overrides the predictor's view of that transaction.
                if (row_typed) begin
                    if (row_emit)
                        pending_commands.push_back(row_verdict);
                end
                else if (emit) begin
                    pending_commands.push_back(v);
                end
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch once on request.
    initial begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request && !hold_taken) begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Offer one byte and hold it until the transaction completes. Idle gaps come
    // before the byte, so a valid that stays high is never dropped and raised.
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic emit = 1'b0, input logic [7:0] cmd = NO_COMMAND,
                             input logic found = 1'b0);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_typed           = typed;
        row_emit            = emit;
        row_verdict.command = cmd;
        row_verdict.found   = found;
        in_valid <= 1'b1;
        rx_byte  <= b;
        items_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected command has come back, then let
    // the block finish any byte that makes no result.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random payload byte: mostly from a narrow alphabet so repeats are common,
    // sometimes 0xFF or the header value itself.
    function automatic logic [7:0] payload_pick(input logic [7:0] base, input int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return cur_header;
        if (r < 14)
            return NO_COMMAND;
        if (r < 20)
            return 8'($urandom_range(0, 255));
        return base + 8'($urandom_range(0, spread));
    endfunction

    // Send one random sequence: mostly well-formed frames with random content,
    // some noise, broken header pairs and frames cut short.
    task automatic send_frame();
        int         kind;
        int         n;
        int         k;
        int         spread;
        logic [7:0] base;
        logic [7:0] b;
        kind   = $urandom_range(0, 99);
        n      = (cur_count > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(cur_count);
        spread = $urandom_range(0, 15);
        base   = 8'($urandom_range(0, 255));
        if (kind < 8) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 14) begin
            // Single header byte followed by something else: restart the hunt.
            send_byte(cur_header);
            send_byte(cur_header ^ 8'($urandom_range(1, 255)));
        end
        else begin
            send_byte(cur_header);
            send_byte(cur_header);
            // Cut some frames short; the next sequence lands in their payload.
            if (kind < 20 && n > 1)
                n = $urandom_range(1, n - 1);
            // A count of zero closes on the first byte, header or not.
            if (n == 0) begin
                send_byte(payload_pick(base, spread));
            end
            else begin
                k = 0;
                while (k < n) begin
                    b = payload_pick(base, spread);
                    send_byte(b);
                    if (b != cur_header)
                        k++;
                end
            end
        end
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        logic [7:0] hdr;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SYNC_BYTE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        row_typed   = 1'b0;
        row_emit    = 1'b0;
        row_verdict = '0;

        // Directed table. Columns: kind, register, value, typed, result, command, found.
        script = '{
            // After reset: header 0x00, four payload bytes, header value skipped.
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h00, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h00, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h12, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h00, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h34, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h12, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h56, 1'b1, 1'b1, 8'h12,      1'b1},
            // Count of zero: the byte after the header pair closes the frame.
            '{ROW_REG,  REG_FRAME_LEN, 8'h00, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_REG,  REG_SYNC_BYTE, 8'hFF, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hFF, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hFF, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hFF, 1'b1, 1'b1, NO_COMMAND, 1'b0},
            // Count above capacity acts as eight; 0xFF repeats first and wins.
            '{ROW_REG,  REG_SYNC_BYTE, 8'hA5, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_REG,  REG_FRAME_LEN, 8'h0F, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hA5, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hA5, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hFF, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h00, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hFF, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h00, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h01, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h02, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h03, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h7E, 1'b1, 1'b1, NO_COMMAND, 1'b0},
            // Broken header pair, then a two-byte frame with no repetition.
            '{ROW_REG,  REG_FRAME_LEN, 8'h02, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hA5, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h01, 1'b1, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hA5, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'hA5, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h7F, 1'b0, 1'b0, NO_COMMAND, 1'b0},
            '{ROW_BYTE, REG_SYNC_BYTE, 8'h80, 1'b1, 1'b1, NO_COMMAND, 1'b0}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part runs with the sender mostly busy and the receiver stalling.
        send_idle_pct = 10;
        recv_idle_pct = 60;
        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) begin
                wait_idle();
                write_reg(script[r].reg_index, script[r].value);
            end
            else begin
                send_byte(script[r].value, script[r].typed, script[r].emit,
                          script[r].command, script[r].found);
            end
        end

        // Random phases. Each one drains the block, rewrites both registers and
        // then streams sequences; a phase may end mid-frame, so the new count
        // also lands in the middle of a frame.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase < 4) begin
                send_idle_pct = 10;
                recv_idle_pct = 60;
            end
            else if (phase < 8) begin
                send_idle_pct = 60;
                recv_idle_pct = 10;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                hdr = 8'h00;
            else if (phase == 1)
                hdr = 8'hFF;
            else
                hdr = 8'($urandom_range(0, 255));
            write_reg(REG_SYNC_BYTE, hdr);
            write_reg(REG_FRAME_LEN, 8'(phase_count[phase]));
            // Hold the output off while bytes keep coming, so the queue fills
            // and the input stalls.
            if (phase == 10)
                hold_request = 1;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("tb_redundant_command_deframer passed");
        else
            $display("tb_redundant_command_deframer failed");
        $finish;
    end

endmodule
